// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/tfdc_pkg.sv -----
// ----------------------------------------------------------------------------
// tfdc_pkg
// Types and constants shared by the frame deframer and classifier.
// ----------------------------------------------------------------------------
package tfdc_pkg;

  localparam int LEN_W = 11;

  // Parser phases within one record.
  typedef enum logic [1:0] {
    PH_PREFIX = 2'd0,
    PH_LENGTH = 2'd1,
    PH_BODY   = 2'd2,
    PH_SKIP   = 2'd3
  } phase_t;

  // Register indexes on the configuration port (byte address bit 2).
  localparam logic REG_PREFIX = 1'b0;

  // Protocol codes.
  localparam logic [15:0] ETH_ARP  = 16'h0806;
  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_IPV6 = 16'h86dd;
  localparam logic [7:0]  PROTO_ICMP   = 8'h01;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [7:0]  PROTO_ICMPV6 = 8'd58;

  // Minimum lengths for each header layer.
  localparam logic [LEN_W-1:0] MIN_ETH  = 11'd14;
  localparam logic [LEN_W-1:0] MIN_IPV4 = 11'd34;
  localparam logic [LEN_W-1:0] MIN_IPV6 = 11'd54;

  // Frame byte offsets of the captured header fields.
  localparam logic [LEN_W-1:0] OFS_DEST    = 11'd0;
  localparam logic [LEN_W-1:0] OFS_ETH_HI  = 11'd12;
  localparam logic [LEN_W-1:0] OFS_ETH_LO  = 11'd13;
  localparam logic [LEN_W-1:0] OFS_V6_NH   = 11'd20;
  localparam logic [LEN_W-1:0] OFS_V4_PROT = 11'd23;

  // One result transfer.
  typedef struct packed {
    logic [7:0]       frame_byte;
    logic [LEN_W-1:0] frame_length;
    logic             first_byte;
    logic             last_byte;
    logic             high_priority;
    logic             truncated;
  } frame_res_t;

endpackage

// ----- hdl/tfdc_classify.sv -----
// ----------------------------------------------------------------------------
// tfdc_classify
// Priority decision from the captured header fields of one frame.
// ----------------------------------------------------------------------------
module tfdc_classify (
  input  logic [tfdc_pkg::LEN_W-1:0] frame_length,
  input  logic [15:0]                ethertype,
  input  logic [7:0]                 ipv4_protocol,
  input  logic [7:0]                 ipv6_next_header,
  input  logic                       dest_group_bit,
  output logic                       high_priority
);
  import tfdc_pkg::*;

  // ARP, TCP and ICMP/ICMPv6 are high once the header is complete; UDP only when unicast.
  always_comb begin
    high_priority = 1'b0;
    if (frame_length >= MIN_ETH) begin
      if (ethertype == ETH_ARP) begin
        high_priority = 1'b1;
      end else if (ethertype == ETH_IPV4) begin
        if (frame_length >= MIN_IPV4) begin
          if (ipv4_protocol == PROTO_TCP || ipv4_protocol == PROTO_ICMP) begin
            high_priority = 1'b1;
          end else if (ipv4_protocol == PROTO_UDP) begin
            high_priority = !dest_group_bit;
          end
        end
      end else if (ethertype == ETH_IPV6) begin
        if (frame_length >= MIN_IPV6) begin
          if (ipv6_next_header == PROTO_TCP || ipv6_next_header == PROTO_ICMPV6) begin
            high_priority = 1'b1;
          end else if (ipv6_next_header == PROTO_UDP) begin
            high_priority = !dest_group_bit;
          end
        end
      end
    end
  end

endmodule

// ----- hdl/tfdc_parser.sv -----
// ----------------------------------------------------------------------------
// tfdc_parser
// Record parser: skips the prefix, assembles the length word, walks the
// frame body and captures the header fields needed for classification.
// ----------------------------------------------------------------------------
module tfdc_parser #(
  parameter int MAX_FRAME = 1600
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_write,
  input  logic                 prefix_enable,
  output logic                 res_valid,
  output tfdc_pkg::frame_res_t res
);
  import tfdc_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME);

  // Parser state.
  phase_t           phase, phase_next;
  logic [1:0]       header_count, header_count_next;
  logic [LEN_W-1:0] len_low, len_low_next;
  logic             len_big, len_big_next;
  logic [LEN_W-1:0] byte_index, byte_index_next;
  logic [LEN_W-1:0] cur_len, cur_len_next;
  logic             dest_group, dest_group_next;
  logic [15:0]      ethertype, ethertype_next;
  logic [7:0]       v6_next_hdr, v6_next_hdr_next;
  logic [7:0]       v4_proto, v4_proto_next;

  phase_t           phase_eff;
  logic [LEN_W:0]   index_inc;
  logic             last;
  logic             trunc;
  logic [LEN_W-1:0] asm_low;
  logic             asm_big;
  logic             len_bad;
  logic             cap_group;
  logic [15:0]      cap_eth;
  logic [7:0]       cap_v6;
  logic [7:0]       cap_v4;
  logic             high;

  // With no prefix, a record starts directly at the length word.
  assign phase_eff = (phase == PH_PREFIX && header_count == 2'd0 && !prefix_enable)
                     ? PH_LENGTH : phase;

  // Position in the frame body.
  assign index_inc = {1'b0, byte_index} + 1'b1;
  assign last      = index_inc >= {1'b0, cur_len};
  assign trunc     = end_of_write && !last;

  // Header fields including the byte at hand, so a final byte counts.
  assign cap_group = (byte_index == OFS_DEST) ? data_byte[0] : dest_group;
  assign cap_eth   = (byte_index == OFS_ETH_HI) ? {data_byte, ethertype[7:0]} :
                     (byte_index == OFS_ETH_LO) ? {ethertype[15:8], data_byte} : ethertype;
  assign cap_v6    = (byte_index == OFS_V6_NH)   ? data_byte : v6_next_hdr;
  assign cap_v4    = (byte_index == OFS_V4_PROT) ? data_byte : v4_proto;

  // Length word assembly: low 11 bits kept, any higher bit marks it too big.
  always_comb begin
    asm_low = len_low;
    asm_big = len_big;
    case (header_count)
      2'd0: asm_low[7:0] = data_byte;
      2'd1: begin
        asm_low[10:8] = data_byte[2:0];
        asm_big       = len_big || (|data_byte[7:3]);
      end
      default: asm_big = len_big || (|data_byte);
    endcase
  end

  assign len_bad = asm_big || asm_low == '0 || asm_low > MAX_LEN;

  tfdc_classify u_classify (
    .frame_length     (cur_len),
    .ethertype        (cap_eth),
    .ipv4_protocol    (cap_v4),
    .ipv6_next_header (cap_v6),
    .dest_group_bit   (cap_group),
    .high_priority    (high)
  );

  // Next-state logic.
  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    len_low_next      = len_low;
    len_big_next      = len_big;
    byte_index_next   = byte_index;
    cur_len_next      = cur_len;
    dest_group_next   = dest_group;
    ethertype_next    = ethertype;
    v6_next_hdr_next  = v6_next_hdr;
    v4_proto_next     = v4_proto;
    if (advance) begin
      unique case (phase_eff)
        PH_PREFIX: begin
          header_count_next = header_count + 2'd1;
          if (header_count == 2'd3) begin
            phase_next = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          phase_next   = PH_LENGTH;
          len_low_next = asm_low;
          len_big_next = asm_big;
          if (header_count == 2'd3) begin
            header_count_next = 2'd0;
            len_low_next      = '0;
            len_big_next      = 1'b0;
            if (len_bad) begin
              phase_next = PH_SKIP;
            end else begin
              cur_len_next    = asm_low;
              byte_index_next = '0;
              phase_next      = PH_BODY;
            end
          end else begin
            header_count_next = header_count + 2'd1;
          end
        end
        PH_BODY: begin
          dest_group_next  = cap_group;
          ethertype_next   = cap_eth;
          v6_next_hdr_next = cap_v6;
          v4_proto_next    = cap_v4;
          byte_index_next  = index_inc[LEN_W-1:0];
          if (last) begin
            phase_next        = PH_PREFIX;
            header_count_next = 2'd0;
            len_low_next      = '0;
            len_big_next      = 1'b0;
          end
        end
        PH_SKIP: begin
          phase_next = PH_SKIP;
        end
        default: phase_next = PH_PREFIX;
      endcase
      // The end of a write always returns to a fresh record.
      if (end_of_write) begin
        phase_next        = PH_PREFIX;
        header_count_next = 2'd0;
        len_low_next      = '0;
        len_big_next      = 1'b0;
      end
    end
  end

  // Output logic: one result for each frame body byte.
  always_comb begin
    res_valid         = advance && phase_eff == PH_BODY;
    res.frame_byte    = data_byte;
    res.frame_length  = cur_len;
    res.first_byte    = byte_index == '0;
    res.last_byte     = last || trunc;
    res.high_priority = last && !trunc && high;
    res.truncated     = trunc;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_PREFIX;
      header_count <= 2'd0;
      len_low      <= '0;
      len_big      <= 1'b0;
      byte_index   <= '0;
      cur_len      <= '0;
      dest_group   <= 1'b0;
      ethertype    <= '0;
      v6_next_hdr  <= '0;
      v4_proto     <= '0;
    end else begin
      phase        <= phase_next;
      header_count <= header_count_next;
      len_low      <= len_low_next;
      len_big      <= len_big_next;
      byte_index   <= byte_index_next;
      cur_len      <= cur_len_next;
      dest_group   <= dest_group_next;
      ethertype    <= ethertype_next;
      v6_next_hdr  <= v6_next_hdr_next;
      v4_proto     <= v4_proto_next;
    end
  end

endmodule

// ----- hdl/tfdc_skid.sv -----
// ----------------------------------------------------------------------------
// tfdc_skid
// Output register with a skid stage, so the ready toward the parser is
// registered and a result can be taken while another waits.
// ----------------------------------------------------------------------------
module tfdc_skid (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  tfdc_pkg::frame_res_t push_data,
  output logic                 space,
  output logic                 out_valid,
  output tfdc_pkg::frame_res_t out_data,
  input  logic                 out_ready,
  output logic                 skid_valid
);
  import tfdc_pkg::*;

  frame_res_t skid_data;

  // A push is only made while the skid stage is empty.
  assign space = !skid_valid;

  // Valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ----- hdl/tx_frame_deframe_classify.sv -----
// ----------------------------------------------------------------------------
// tx_frame_deframe_classify
// Splits a write buffer byte stream into frames and classifies each frame.
// ----------------------------------------------------------------------------
// Input stream (s_*): one byte of the write buffer per transfer, with tlast
// on the final byte of the write. Output stream (m_*): one transfer per frame
// byte carrying the byte and the frame length; tlast marks the final byte of
// a frame, and tuser carries the first-byte flag, the priority decision
// (valid on a complete last byte) and the truncation flag.
// An accepted byte passes an input register and then the parser into an
// output register (or, while the receiver stalls, the skid stage), from
// which it is taken. One byte is taken every cycle as long as the receiver
// keeps up; the rate is set by the single parse step per byte. When the
// receiver stalls, a skid stage holds one more result and then s_tready
// drops. Bytes of prefixes, length words and skipped records produce no
// output transfer.
// Reset clears the parser to the start of a record, empties both stages and
// clears the prefix register. The APB port writes prefix_enable at address 0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tx_frame_deframe_classify #(
  parameter int MAX_FRAME = 1600
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_write
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] frame_byte, [18:8] frame_length, [23:19] zero
  output logic        m_tlast,   // last_byte
  output logic [2:0]  m_tuser,   // [0] first_byte, [1] high_priority, [2] truncated
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tfdc_pkg::*;

  logic       prefix_enable;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eow;
  logic       advance;
  logic       buf_space;
  logic       res_valid;
  frame_res_t res;
  frame_res_t out_res;
  logic       skid_valid;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PREFIX) ? {31'd0, prefix_enable} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_enable <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_PREFIX) begin
      prefix_enable <= pwdata[0];
    end
  end

  // Input register; it moves on whenever the output buffer has room.
  assign advance  = in_valid && buf_space;
  assign s_tready = !in_valid || buf_space;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_eow  <= s_tlast;
    end
  end

  // Parse and classify.
  tfdc_parser #(
    .MAX_FRAME (MAX_FRAME)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .data_byte     (in_byte),
    .end_of_write  (in_eow),
    .prefix_enable (prefix_enable),
    .res_valid     (res_valid),
    .res           (res)
  );

  // Output register with skid stage.
  tfdc_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_data  (res),
    .space      (buf_space),
    .out_valid  (m_tvalid),
    .out_data   (out_res),
    .out_ready  (m_tready),
    .skid_valid (skid_valid)
  );

  // Pack the output transfer.
  assign m_tdata = {5'd0, out_res.frame_length, out_res.frame_byte};
  assign m_tlast = out_res.last_byte;
  assign m_tuser = {out_res.truncated, out_res.high_priority, out_res.first_byte};

  // Checks.
  `ASSERT_IMPLIES(a_res_on_advance, clk, rst, res_valid, advance, "result without a parsed byte")
  `ASSERT_IMPLIES(a_skid_behind_out, clk, rst, skid_valid, m_tvalid && !s_tready || !in_valid && m_tvalid, "skid stage holds data while output register is empty")
  `ASSERT_NEXT(a_skid_refill, clk, rst, skid_valid && m_tready, m_tvalid, "output register not refilled from skid stage")
  `ASSERT_IMPLIES(a_high_on_last, clk, rst, m_tvalid && m_tuser[1], m_tlast && !m_tuser[2], "priority flagged off a complete last byte")

endmodule

// ----- dv/tx_frame_deframe_classify_tb.sv -----
// ----------------------------------------------------------------------------
// tx_frame_deframe_classify_tb
// Self-checking bench for the write buffer deframer and priority classifier.
// Write buffers built from length-prefixed records are streamed in one byte
// per transfer. An in-bench parser predicts every output transfer, and each
// one is compared field by field as it leaves the block. Directed tests
// cover short frames, priority rules, cut headers, bad lengths, truncation,
// prefix changes and the largest frame. Random traffic, a long output
// stall and a gap-free stretch follow.
// ----------------------------------------------------------------------------
module tx_frame_deframe_classify_tb;
  import tfdc_pkg::*;

  localparam int MAX_FRAME    = 1600;
  localparam int RANDOM_BYTES = 450;
  localparam int IDLE_GAP     = 4;
  localparam int HOLD_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PRINT_LIMIT  = 50;

  // Codes that fall outside every high-priority rule.
  localparam logic [15:0] ETH_LLDP   = 16'h88cc;
  localparam logic [7:0]  PROTO_IGMP = 8'd2;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] data_byte
  logic        s_tlast;   // end_of_write
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // [7:0] frame_byte, [18:8] frame_length, [23:19] zero
  logic        m_tlast;   // last_byte
  logic [2:0]  m_tuser;   // [0] first_byte, [1] high_priority, [2] truncated
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Parser state mirrored by the bench.
  logic        prefix_on;
  phase_t      rec_phase;
  logic [1:0]  hdr_count;
  logic [31:0] len_word;
  logic [10:0] body_pos;
  logic [10:0] body_len;
  logic        dst_group;
  logic [15:0] ether_type;
  logic [7:0]  v6_next;
  logic [7:0]  v4_proto;

  frame_res_t  pending_frame_bytes[$];
  logic [7:0]  wr_bytes[$];

  bit src_gaps_on  = 1'b0;
  bit sink_gaps_on = 1'b0;
  int hold_left    = 0;
  int bytes_sent   = 0;
  int cycle_count  = 0;
  int errors       = 0;

  tx_frame_deframe_classify #(
    .MAX_FRAME(MAX_FRAME)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_LIMIT) $display("ERROR cycle %0d: %s", cycle_count, msg);
  endtask

  // Queue decision for a completed frame, from the captured header fields.
  function automatic logic high_queue_for(input logic [10:0] len);
    logic unicast;
    unicast = ~dst_group;
    if (len < MIN_ETH) return 1'b0;
    if (ether_type == ETH_ARP) return 1'b1;
    if (ether_type == ETH_IPV4) begin
      if (len < MIN_IPV4) return 1'b0;
      if (v4_proto == PROTO_TCP || v4_proto == PROTO_ICMP) return 1'b1;
      if (v4_proto == PROTO_UDP) return unicast;
      return 1'b0;
    end
    if (ether_type == ETH_IPV6) begin
      if (len < MIN_IPV6) return 1'b0;
      if (v6_next == PROTO_TCP || v6_next == PROTO_ICMPV6) return 1'b1;
      if (v6_next == PROTO_UDP) return unicast;
      return 1'b0;
    end
    return 1'b0;
  endfunction

  task automatic restart_record;
    rec_phase = PH_PREFIX;
    hdr_count = 2'd0;
    len_word  = 32'd0;
  endtask

  // Advance the mirrored parser by one accepted byte and queue its result.
  task automatic deframe_byte(input logic [7:0] b, input logic eow);
    frame_res_t res;
    logic       at_end;
    logic       cut;
    if (rec_phase == PH_PREFIX && hdr_count == 2'd0 && !prefix_on) rec_phase = PH_LENGTH;
    case (rec_phase)
      PH_PREFIX: begin
        hdr_count = hdr_count + 2'd1;
        if (hdr_count == 2'd0) rec_phase = PH_LENGTH;
      end
      PH_LENGTH: begin
        len_word = len_word | ({24'd0, b} << (8 * hdr_count));
        if (hdr_count == 2'd3) begin
          hdr_count = 2'd0;
          if (len_word == 32'd0 || len_word > MAX_FRAME) begin
            rec_phase = PH_SKIP;
          end else begin
            body_len  = len_word[10:0];
            body_pos  = 11'd0;
            rec_phase = PH_BODY;
          end
          len_word = 32'd0;
        end else begin
          hdr_count = hdr_count + 2'd1;
        end
      end
      PH_BODY: begin
        at_end = (int'(body_pos) + 1 >= int'(body_len));
        cut    = eow && !at_end;
        if (body_pos == OFS_DEST)    dst_group = b[0];
        if (body_pos == OFS_ETH_HI)  ether_type[15:8] = b;
        if (body_pos == OFS_ETH_LO)  ether_type[7:0] = b;
        if (body_pos == OFS_V6_NH)   v6_next = b;
        if (body_pos == OFS_V4_PROT) v4_proto = b;
        res.frame_byte    = b;
        res.frame_length  = body_len;
        res.first_byte    = (body_pos == 11'd0);
        res.last_byte     = at_end || cut;
        res.high_priority = at_end ? high_queue_for(body_len) : 1'b0;
        res.truncated     = cut;
        pending_frame_bytes.push_back(res);
        body_pos = body_pos + 11'd1;
        if (at_end) restart_record();
      end
      default: begin
      end
    endcase
    if (eow) restart_record();
  endtask

  // Check every output transfer against the oldest expected frame byte.
  always @(posedge clk) begin : check_out
    frame_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_frame_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected output transfer, byte %02h", m_tdata[7:0]));
      end else begin
        want = pending_frame_bytes.pop_front();
        if (m_tdata[7:0] !== want.frame_byte)
          report_mismatch($sformatf("frame_byte %02h, expected %02h",
                                    m_tdata[7:0], want.frame_byte));
        if (m_tdata[18:8] !== want.frame_length)
          report_mismatch($sformatf("frame_length %0d, expected %0d",
                                    m_tdata[18:8], want.frame_length));
        if (m_tuser[0] !== want.first_byte)
          report_mismatch($sformatf("first_byte %b, expected %b", m_tuser[0], want.first_byte));
        if (m_tlast !== want.last_byte)
          report_mismatch($sformatf("last_byte %b, expected %b", m_tlast, want.last_byte));
        if (m_tuser[1] !== want.high_priority)
          report_mismatch($sformatf("high_priority %b, expected %b",
                                    m_tuser[1], want.high_priority));
        if (m_tuser[2] !== want.truncated)
          report_mismatch($sformatf("truncated %b, expected %b", m_tuser[2], want.truncated));
      end
    end
  end

  // Output side: random stall bursts plus a long hold-off on request.
  initial begin : sink_ctrl
    int stall;
    stall    = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else if (sink_gaps_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        stall = $urandom_range(1, 5) - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offer one byte, optionally after a gap, and wait for its transfer.
  task automatic send_byte(input logic [7:0] b, input logic eow);
    if (src_gaps_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eow;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    deframe_byte(b, eow);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Send the built buffer; tlast goes on its final byte when the write ends.
  task automatic send_buf(input bit end_write);
    for (int i = 0; i < wr_bytes.size(); i++)
      send_byte(wr_bytes[i], end_write && (i == wr_bytes.size() - 1));
    wr_bytes.delete();
  endtask

  // Stop offering and wait until every expected byte has left the block.
  task automatic wait_idle;
    s_tvalid <= 1'b0;
    while (pending_frame_bytes.size() != 0) @(negedge clk);
    repeat (IDLE_GAP) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_prefix(input logic val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_PREFIX, 2'b00};
    pwdata  <= {31'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    prefix_on = val;
  endtask

  task automatic add_header(input logic [31:0] len);
    if (prefix_on) repeat (4) wr_bytes.push_back(8'($urandom_range(0, 255)));
    for (int k = 0; k < 4; k++) wr_bytes.push_back(len[8*k +: 8]);
  endtask

  // One full record whose header fields steer the priority decision.
  task automatic add_record(input int len, input logic [15:0] etype,
                            input logic [7:0] proto, input logic mcast);
    logic [7:0] fb;
    add_header(len);
    for (int i = 0; i < len; i++) begin
      fb = 8'($urandom_range(0, 255));
      if (i == OFS_DEST) fb[0] = mcast;
      if (i == OFS_ETH_HI) fb = etype[15:8];
      if (i == OFS_ETH_LO) fb = etype[7:0];
      if (etype == ETH_IPV4 && i == OFS_V4_PROT) fb = proto;
      if (etype == ETH_IPV6 && i == OFS_V6_NH) fb = proto;
      wr_bytes.push_back(fb);
    end
  endtask

  // Random record, with lengths clustered around the header size limits.
  task automatic add_random_record(output int len);
    int         sel;
    logic [15:0] et;
    logic [7:0]  pr;
    sel = $urandom_range(0, 9);
    if (sel < 2)      et = ETH_ARP;
    else if (sel < 5) et = ETH_IPV4;
    else if (sel < 8) et = ETH_IPV6;
    else              et = 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 5))
      0:       pr = PROTO_TCP;
      1:       pr = PROTO_ICMP;
      2, 3:    pr = PROTO_UDP;
      4:       pr = PROTO_ICMPV6;
      default: pr = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 7))
      0:       len = $urandom_range(1, 13);
      1:       len = $urandom_range(14, 20);
      2, 3:    len = $urandom_range(33, 40);
      4, 5:    len = $urandom_range(53, 60);
      6:       len = $urandom_range(14, 120);
      default: len = $urandom_range(1, 300);
    endcase
    add_record(len, et, pr, 1'($urandom_range(0, 1)));
  endtask

  // One random write: mostly good records, sometimes a bad length, a cut
  // header or a frame cut short by the end of the write.
  task automatic random_write;
    int          n_rec;
    int          pick;
    int          last_len;
    logic [31:0] bad_len;
    n_rec = $urandom_range(1, 3);
    for (int r = 0; r < n_rec; r++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        bad_len = $urandom_range(0, 1) ? 32'd0 : 32'($urandom());
        if (bad_len != 0 && bad_len <= MAX_FRAME) bad_len = bad_len + MAX_FRAME;
        add_header(bad_len);
        repeat ($urandom_range(0, 6)) wr_bytes.push_back(8'($urandom_range(0, 255)));
        break;
      end
      if (pick == 1) begin
        repeat ($urandom_range(1, prefix_on ? 7 : 3))
          wr_bytes.push_back(8'($urandom_range(0, 255)));
        break;
      end
      add_random_record(last_len);
      if (pick == 2) begin
        repeat ($urandom_range(1, last_len)) void'(wr_bytes.pop_back());
        break;
      end
    end
  endtask

  task automatic test_register_setup;
    write_prefix(1'b0);
  endtask

  // Single-byte and two-byte frames with extreme byte values, and the
  // shortest frame that can carry an ethertype.
  task automatic test_short_frames;
    add_header(1);
    wr_bytes.push_back(8'h00);
    add_header(2);
    wr_bytes.push_back(8'hff);
    wr_bytes.push_back(8'hff);
    add_record(13, ETH_ARP, PROTO_TCP, 1'b0);
    add_record(14, ETH_ARP, PROTO_TCP, 1'b1);
    send_buf(1'b1);
  endtask

  // Each priority rule, including frames just short of a full header.
  task automatic test_priority_rules;
    add_record(34, ETH_IPV4, PROTO_TCP, 1'b1);
    add_record(40, ETH_IPV4, PROTO_ICMP, 1'b0);
    add_record(34, ETH_IPV4, PROTO_UDP, 1'b0);
    add_record(34, ETH_IPV4, PROTO_UDP, 1'b1);
    add_record(33, ETH_IPV4, PROTO_TCP, 1'b0);
    add_record(34, ETH_IPV4, PROTO_IGMP, 1'b0);
    send_buf(1'b1);
    add_record(54, ETH_IPV6, PROTO_ICMPV6, 1'b1);
    add_record(54, ETH_IPV6, PROTO_UDP, 1'b0);
    add_record(54, ETH_IPV6, PROTO_UDP, 1'b1);
    add_record(53, ETH_IPV6, PROTO_TCP, 1'b0);
    add_record(54, ETH_IPV6, PROTO_IGMP, 1'b0);
    add_record(20, ETH_LLDP, PROTO_TCP, 1'b0);
    send_buf(1'b1);
  endtask

  // Writes that end inside the prefix or the length word, or right on it.
  task automatic test_header_cuts;
    wr_bytes.push_back(8'h05);
    wr_bytes.push_back(8'h00);
    send_buf(1'b1);
    add_header(8);
    send_buf(1'b1);
    wait_idle();
    write_prefix(1'b1);
    repeat (3) wr_bytes.push_back(8'($urandom_range(0, 255)));
    send_buf(1'b1);
    add_header(6);
    send_buf(1'b1);
    add_record(3, ETH_ARP, PROTO_TCP, 1'b0);
    send_buf(1'b1);
    wait_idle();
    write_prefix(1'b0);
  endtask

  // Zero and oversized lengths stop parsing until the write ends.
  task automatic test_bad_lengths;
    add_header(0);
    add_record(5, ETH_ARP, PROTO_TCP, 1'b0);
    send_buf(1'b1);
    add_header(MAX_FRAME + 1);
    repeat (3) wr_bytes.push_back(8'($urandom_range(0, 255)));
    send_buf(1'b1);
    add_header(32'hffff_ffff);
    wr_bytes.push_back(8'h00);
    send_buf(1'b1);
    add_header(32'h0001_0005);
    repeat (2) wr_bytes.push_back(8'($urandom_range(0, 255)));
    send_buf(1'b1);
    add_record(2, ETH_ARP, PROTO_TCP, 1'b0);
    send_buf(1'b1);
  endtask

  // Frames cut short by the end of the write, then one ending exactly on it.
  task automatic test_truncation;
    add_record(10, ETH_ARP, PROTO_TCP, 1'b0);
    repeat (4) void'(wr_bytes.pop_back());
    send_buf(1'b1);
    add_record(14, ETH_ARP, PROTO_TCP, 1'b0);
    repeat (13) void'(wr_bytes.pop_back());
    send_buf(1'b1);
    add_record(4, ETH_ARP, PROTO_TCP, 1'b0);
    send_buf(1'b1);
  endtask

  // A prefix setting changed inside a record only applies from the next one.
  task automatic test_prefix_change;
    wait_idle();
    write_prefix(1'b1);
    repeat (2) wr_bytes.push_back(8'($urandom_range(0, 255)));
    send_buf(1'b0);
    wait_idle();
    write_prefix(1'b0);
    repeat (2) wr_bytes.push_back(8'($urandom_range(0, 255)));
    add_header(5);
    repeat (5) wr_bytes.push_back(8'($urandom_range(0, 255)));
    add_record(3, ETH_ARP, PROTO_TCP, 1'b0);
    send_buf(1'b0);
    wait_idle();
    wr_bytes.push_back(8'h04);
    wr_bytes.push_back(8'h00);
    send_buf(1'b0);
    wait_idle();
    write_prefix(1'b1);
    wr_bytes.push_back(8'h00);
    wr_bytes.push_back(8'h00);
    repeat (4) wr_bytes.push_back(8'($urandom_range(0, 255)));
    add_record(2, ETH_ARP, PROTO_TCP, 1'b0);
    send_buf(1'b1);
    wait_idle();
    write_prefix(1'b0);
  endtask

  task automatic test_max_frame;
    add_record(MAX_FRAME, ETH_IPV6, PROTO_TCP, 1'b0);
    send_buf(1'b1);
  endtask

  // Random writes with idling on both sides and occasional prefix changes.
  task automatic test_random_traffic;
    int start;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if ($urandom_range(0, 7) == 0) begin
        wait_idle();
        write_prefix(1'($urandom_range(0, 1)));
      end
      src_gaps_on  = ($urandom_range(0, 3) != 0);
      sink_gaps_on = ($urandom_range(0, 3) != 0);
      random_write();
      send_buf(1'b1);
    end
  endtask

  // Long output stall while input keeps coming, then a full drain.
  task automatic test_backpressure;
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    s_tvalid <= 1'b0;
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    @(negedge clk);
    add_record(120, ETH_IPV4, PROTO_UDP, 1'b0);
    add_record(40, ETH_IPV6, PROTO_TCP, 1'b1);
    send_buf(1'b1);
    wait_idle();
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_steady_stream;
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    repeat (4) begin
      random_write();
      send_buf(1'b1);
    end
  endtask

  // Test sequence.
  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'd0;
    s_tlast  = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = 3'd0;
    pwdata   = 32'd0;
    prefix_on  = 1'b0;
    body_pos   = 11'd0;
    body_len   = 11'd0;
    dst_group  = 1'b0;
    ether_type = 16'd0;
    v6_next    = 8'd0;
    v4_proto   = 8'd0;
    restart_record();
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_register_setup();
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
    test_short_frames();
    test_priority_rules();
    test_header_cuts();
    test_bad_lengths();
    test_truncation();
    test_prefix_change();
    test_max_frame();
    test_random_traffic();
    test_backpressure();
    test_steady_stream();
    wait_idle();
    repeat (8) @(negedge clk);
    if (pending_frame_bytes.size() != 0)
      report_mismatch($sformatf("%0d expected frame bytes never arrived",
                                pending_frame_bytes.size()));
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
